// ===== rtl/radius_attribute_deframer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the RADIUS attribute deframer
// ---------------------------------------------------------------------------
`ifndef RADIUS_ATTRIBUTE_DEFRAMER_MACROS_SVH
`define RADIUS_ATTRIBUTE_DEFRAMER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RAD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rad: implication check failed");

// antecedent implies consequent in the next cycle
`define RAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rad: next-cycle check failed");

`endif

// ===== rtl/rad_pkg.sv =====
// ---------------------------------------------------------------------------
// rad_pkg
// Types, constants and the attribute class table of the RADIUS deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package rad_pkg;

  localparam logic [15:0] MAX_PACKET_BYTES = 16'd4096;
  localparam logic [15:0] HEADER_BYTES     = 16'd20;
  localparam logic [15:0] POS_SAT          = 16'hFFFF;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // value classes
  localparam logic [2:0] CLS_STRING = 3'd0;
  localparam logic [2:0] CLS_ENCR   = 3'd1;
  localparam logic [2:0] CLS_CHAP   = 3'd2;
  localparam logic [2:0] CLS_IPADDR = 3'd3;
  localparam logic [2:0] CLS_INT    = 3'd4;
  localparam logic [2:0] CLS_BYTES  = 3'd5;
  localparam logic [2:0] CLS_VSA    = 3'd6;
  localparam logic [2:0] CLS_NONE   = 3'd7;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT_PKT = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_BAD_CODE  = 3'd3;
  localparam logic [2:0] ST_EAP_NOMA  = 3'd4;
  localparam logic [2:0] ST_ATTR_LEN  = 3'd5;

  localparam logic [7:0] ATTR_EAP_MSG  = 8'd79;
  localparam logic [7:0] ATTR_MSG_AUTH = 8'd80;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  attr_code;
    logic [2:0]  attr_class;
    logic [12:0] value_offset;
    logic [7:0]  value_length;
    logic [7:0]  packet_code;
    logic [7:0]  packet_ident;
    logic [15:0] packet_length;
    logic [63:0] auth_high;
    logic [63:0] auth_low;
    logic [2:0]  status;
    logic        last;
  } out_t;

  // one queued transaction: an optional record and an optional summary
  typedef struct packed {
    logic        has_rec;
    logic [7:0]  attr_code;
    logic [2:0]  attr_class;
    logic [12:0] value_offset;
    logic [7:0]  value_length;
    logic        has_sum;
    logic [7:0]  packet_code;
    logic [7:0]  packet_ident;
    logic [15:0] packet_length;
    logic [63:0] auth_high;
    logic [63:0] auth_low;
    logic [2:0]  status;
  } ev_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic logic [2:0] class_of(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      8'd1, 8'd11, 8'd18, 8'd22, 8'd34, 8'd35, 8'd60, 8'd63: r = CLS_STRING;
      8'd2:                                                  r = CLS_ENCR;
      8'd3:                                                  r = CLS_CHAP;
      8'd4, 8'd8, 8'd9, 8'd14:                               r = CLS_IPADDR;
      8'd5, 8'd6, 8'd7, 8'd10, 8'd12, 8'd13, 8'd15, 8'd16,
      8'd27, 8'd28, 8'd29, 8'd37, 8'd38, 8'd61, 8'd62:       r = CLS_INT;
      8'd19, 8'd20, 8'd24, 8'd25, 8'd30, 8'd31, 8'd32, 8'd33,
      8'd36, 8'd39, 8'd79, 8'd80:                            r = CLS_BYTES;
      8'd26:                                                 r = CLS_VSA;
      default:                                               r = CLS_NONE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rad_front.sv =====
// ---------------------------------------------------------------------------
// rad_front
// Byte parser: captures the header, walks the attributes and queues
// record and summary transactions.
// ---------------------------------------------------------------------------
`default_nettype none

module rad_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire rad_pkg::in_t in_data_i,
  input  wire rad_pkg::fifo_stat_t fifo_stat_i,
  output logic              push_o,
  output rad_pkg::ev_t      ev_o
);
  import rad_pkg::*;

  logic [15:0] pos_q, pos_d;
  logic [15:0] dl_q, dl_d;
  logic [7:0]  hcode_q, hcode_d;
  logic [7:0]  hident_q, hident_d;
  logic [63:0] auth0_q, auth0_d;
  logic [63:0] auth1_q, auth1_d;
  logic [15:0] nas_q, nas_d;
  logic [7:0]  cur_q, cur_d;
  logic [2:0]  err_q, err_d;
  logic        eap_q, eap_d;
  logic        ma_q, ma_d;

  logic        acc;
  logic [7:0]  b;
  logic        walking;
  logic        rec;
  logic [2:0]  cls;
  logic [16:0] pos_p1, nas_p1, nas_pb;
  logic [15:0] cnt;
  logic [2:0]  st;

  assign in_ready_o = !fifo_stat_i.full;
  assign acc        = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_byte;
  assign cls        = class_of(cur_q);
  assign pos_p1     = {1'b0, pos_q} + 17'd1;
  assign nas_p1     = {1'b0, nas_q} + 17'd1;
  assign nas_pb     = {1'b0, nas_q} + {9'd0, b};
  assign walking    = (pos_q >= HEADER_BYTES) && (err_q == ST_OK) &&
                      (dl_q <= MAX_PACKET_BYTES) && (pos_q < dl_q);

  always_comb begin
    hcode_d  = hcode_q;
    hident_d = hident_q;
    dl_d     = dl_q;
    auth0_d  = auth0_q;
    auth1_d  = auth1_q;
    nas_d    = nas_q;
    cur_d    = cur_q;
    err_d    = err_q;
    eap_d    = eap_q;
    ma_d     = ma_q;
    rec      = 1'b0;
    if (pos_q == 16'd0) begin
      hcode_d = b;
    end else if (pos_q == 16'd1) begin
      hident_d = b;
    end else if (pos_q == 16'd2) begin
      dl_d = {b, 8'h00};
    end else if (pos_q == 16'd3) begin
      dl_d = {dl_q[15:8], b};
    end else if (pos_q < 16'd12) begin
      auth0_d = {auth0_q[55:0], b};
    end else if (pos_q < HEADER_BYTES) begin
      auth1_d = {auth1_q[55:0], b};
    end else if (walking) begin
      if (pos_q == nas_q) begin
        cur_d = b;
        if (pos_p1 >= {1'b0, dl_q}) begin
          err_d = ST_ATTR_LEN;
        end
      end else if ({1'b0, pos_q} == nas_p1) begin
        if (b < 8'd2 || nas_pb > {1'b0, dl_q}) begin
          err_d = ST_ATTR_LEN;
        end else if (cls == CLS_NONE) begin
          err_d = ST_BAD_CODE;
        end else begin
          rec   = 1'b1;
          nas_d = nas_pb[15:0];
          if (cur_q == ATTR_EAP_MSG) begin
            eap_d = 1'b1;
          end
          if (cur_q == ATTR_MSG_AUTH) begin
            ma_d = 1'b1;
          end
        end
      end
    end
    pos_d = (pos_q != POS_SAT) ? pos_p1[15:0] : pos_q;
  end

  assign cnt = pos_d;

  always_comb begin
    if (cnt < HEADER_BYTES) begin
      st = ST_SHORT_PKT;
    end else if (dl_d > cnt || dl_d > MAX_PACKET_BYTES) begin
      st = ST_BAD_LEN;
    end else if (err_d != ST_OK) begin
      st = err_d;
    end else if (eap_d && !ma_d) begin
      st = ST_EAP_NOMA;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    ev_o               = '0;
    ev_o.has_rec       = rec;
    if (rec) begin
      ev_o.attr_code    = cur_q;
      ev_o.attr_class   = cls;
      ev_o.value_offset = 13'(nas_q + 16'd2);
      ev_o.value_length = b - 8'd2;
    end
    ev_o.has_sum       = in_data_i.end_of_buffer;
    if (in_data_i.end_of_buffer) begin
      ev_o.packet_code   = hcode_d;
      ev_o.packet_ident  = hident_d;
      ev_o.packet_length = dl_d;
      ev_o.auth_high     = auth0_d;
      ev_o.auth_low      = auth1_d;
      ev_o.status        = st;
    end
  end

  assign push_o = acc && (rec || in_data_i.end_of_buffer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      dl_q     <= '0;
      hcode_q  <= '0;
      hident_q <= '0;
      auth0_q  <= '0;
      auth1_q  <= '0;
      nas_q    <= HEADER_BYTES;
      cur_q    <= '0;
      err_q    <= ST_OK;
      eap_q    <= 1'b0;
      ma_q     <= 1'b0;
    end else if (acc) begin
      if (in_data_i.end_of_buffer) begin
        pos_q    <= '0;
        dl_q     <= '0;
        hcode_q  <= '0;
        hident_q <= '0;
        auth0_q  <= '0;
        auth1_q  <= '0;
        nas_q    <= HEADER_BYTES;
        cur_q    <= '0;
        err_q    <= ST_OK;
        eap_q    <= 1'b0;
        ma_q     <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        dl_q     <= dl_d;
        hcode_q  <= hcode_d;
        hident_q <= hident_d;
        auth0_q  <= auth0_d;
        auth1_q  <= auth1_d;
        nas_q    <= nas_d;
        cur_q    <= cur_d;
        err_q    <= err_d;
        eap_q    <= eap_d;
        ma_q     <= ma_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rad_fifo.sv =====
// ---------------------------------------------------------------------------
// rad_fifo
// Short transaction queue between parser and output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rad_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rad_pkg::ev_t   push_data_i,
  input  wire logic           pop_i,
  output rad_pkg::ev_t        head_o,
  output rad_pkg::fifo_stat_t stat_o
);
  import rad_pkg::*;

  localparam logic [FIFO_CNT_W-1:0] CNT_FULL = FIFO_CNT_W'(FIFO_DEPTH);
  localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);

  ev_t                   mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CNT_FULL);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rad_back.sv =====
// ---------------------------------------------------------------------------
// rad_back
// Output stage: unpacks queued transactions into record and summary
// results through a registered output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "radius_attribute_deframer_macros.svh"

module rad_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rad_pkg::ev_t   head_i,
  input  wire rad_pkg::fifo_stat_t fifo_stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rad_pkg::out_t       out_data_o
);
  import rad_pkg::*;

  logic  out_valid_q, out_valid_d;
  out_t  out_q, out_d;
  logic  phase_q, phase_d;
  logic  load, head_valid;
  out_t  rec_w, sum_w;

  assign head_valid = !fifo_stat_i.empty;
  assign load       = !out_valid_q || out_ready_i;

  always_comb begin
    rec_w              = '0;
    rec_w.result_kind  = KIND_RECORD;
    rec_w.attr_code    = head_i.attr_code;
    rec_w.attr_class   = head_i.attr_class;
    rec_w.value_offset = head_i.value_offset;
    rec_w.value_length = head_i.value_length;
    sum_w               = '0;
    sum_w.result_kind   = KIND_SUMMARY;
    sum_w.packet_code   = head_i.packet_code;
    sum_w.packet_ident  = head_i.packet_ident;
    sum_w.packet_length = head_i.packet_length;
    sum_w.auth_high     = head_i.auth_high;
    sum_w.auth_low      = head_i.auth_low;
    sum_w.status        = head_i.status;
    sum_w.last          = 1'b1;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    phase_d     = phase_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_valid;
      if (head_valid) begin
        if (head_i.has_rec && !phase_q) begin
          out_d = rec_w;
          if (head_i.has_sum) begin
            phase_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          out_d   = sum_w;
          phase_d = 1'b0;
          pop_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RAD_ASSERT_IMPL(a_phase_head, clk_i, rst_ni, phase_q,
                   head_valid && head_i.has_rec && head_i.has_sum)
  `RAD_ASSERT_NEXT(a_phase_set, clk_i, rst_ni,
                   load && head_valid && head_i.has_rec && head_i.has_sum && !phase_q,
                   phase_q && out_valid_q && (out_q.result_kind == KIND_RECORD))
  `RAD_ASSERT_IMPL(a_last_kind, clk_i, rst_ni, out_valid_q,
                   out_q.last == out_q.result_kind)

endmodule

`default_nettype wire

// ===== rtl/radius_attribute_deframer.sv =====
// ---------------------------------------------------------------------------
// radius_attribute_deframer
// Parses a received RADIUS packet byte by byte into attribute records and
// a closing packet summary.
// ---------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (rad_pkg::in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (rad_pkg::out_t)
//
//  One byte per cycle while the queue has room; each result is queued and
//  then registered. A final byte that also closes an attribute yields a
//  record and then a summary, both sent through the single output register.
//  A four-entry transaction queue decouples parser and output; in_ready_o
//  drops only while it is full.
//  Reset clears the parser to packet start at once; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module radius_attribute_deframer (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire rad_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output rad_pkg::out_t out_data_o
);
  import rad_pkg::*;

  fifo_stat_t fstat;
  ev_t        push_ev, head_ev;
  logic       push, pop;

  rad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .fifo_stat_i (fstat),
    .push_o      (push),
    .ev_o        (push_ev)
  );

  rad_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_ev),
    .pop_i       (pop),
    .head_o      (head_ev),
    .stat_o      (fstat)
  );

  rad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_ev),
    .fifo_stat_i (fstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
